>>> hdl/mbcc_pkg.sv
`default_nettype none

package mbcc_pkg;

    // Sequencer program counter and control word fields
    localparam int STEP_W = 5;
    localparam int OP_W   = 5;
    localparam int COND_W = 2;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_ABS      = 5'd0;
    localparam logic [OP_W-1:0] OP_MUL_BODY = 5'd1;
    localparam logic [OP_W-1:0] OP_REL      = 5'd2;
    localparam logic [OP_W-1:0] OP_SEED     = 5'd3;
    localparam logic [OP_W-1:0] OP_DECAY    = 5'd4;
    localparam logic [OP_W-1:0] OP_ERR      = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL_LIM  = 5'd6;
    localparam logic [OP_W-1:0] OP_LIM      = 5'd7;
    localparam logic [OP_W-1:0] OP_MUL_ERR  = 5'd8;
    localparam logic [OP_W-1:0] OP_CUR      = 5'd9;
    localparam logic [OP_W-1:0] OP_MUL_CUR  = 5'd10;
    localparam logic [OP_W-1:0] OP_SCALE    = 5'd11;
    localparam logic [OP_W-1:0] OP_FLOOR    = 5'd12;
    localparam logic [OP_W-1:0] OP_STEPSEL  = 5'd13;
    localparam logic [OP_W-1:0] OP_SLEW     = 5'd14;
    localparam logic [OP_W-1:0] OP_EMIT     = 5'd15;
    localparam logic [OP_W-1:0] OP_HALT     = 5'd16;

    // Jump conditions
    localparam logic [COND_W-1:0] COND_NEVER = 2'd0;
    localparam logic [COND_W-1:0] COND_CMD   = 2'd1;
    localparam logic [COND_W-1:0] COND_STOP  = 2'd2;
    localparam logic [COND_W-1:0] COND_NREL  = 2'd3;

    // Jump targets
    localparam logic [STEP_W-1:0] STEP_FLOOR = 5'd12;
    localparam logic [STEP_W-1:0] STEP_HALT  = 5'd16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_CEILING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_FLOOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PER_RPM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DECAY_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_APPLY_SLEW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SLEW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MIN_REF = 3'd7;

    // Q8 ratios and the speed drop limit
    localparam logic [7:0]  SLOW_RATIO_Q8    = 8'd115;
    localparam logic [7:0]  RELEASE_RATIO_Q8 = 8'd51;
    localparam logic [15:0] DROP_LIMIT_RPM   = 16'd20;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Control program: one word per step
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        begin
            case (step)
                5'd0:    w = '{OP_ABS,      COND_CMD,   STEP_HALT};
                5'd1:    w = '{OP_MUL_BODY, COND_STOP,  STEP_HALT};
                5'd2:    w = '{OP_REL,      COND_NEVER, STEP_HALT};
                5'd3:    w = '{OP_SEED,     COND_NEVER, STEP_HALT};
                5'd4:    w = '{OP_DECAY,    COND_NEVER, STEP_HALT};
                5'd5:    w = '{OP_ERR,      COND_NEVER, STEP_HALT};
                5'd6:    w = '{OP_MUL_LIM,  COND_NEVER, STEP_HALT};
                5'd7:    w = '{OP_LIM,      COND_NEVER, STEP_HALT};
                5'd8:    w = '{OP_MUL_ERR,  COND_NEVER, STEP_HALT};
                5'd9:    w = '{OP_CUR,      COND_NEVER, STEP_HALT};
                5'd10:   w = '{OP_MUL_CUR,  COND_NREL,  STEP_FLOOR};
                5'd11:   w = '{OP_SCALE,    COND_NEVER, STEP_HALT};
                5'd12:   w = '{OP_FLOOR,    COND_NEVER, STEP_HALT};
                5'd13:   w = '{OP_STEPSEL,  COND_NEVER, STEP_HALT};
                5'd14:   w = '{OP_SLEW,     COND_NEVER, STEP_HALT};
                5'd15:   w = '{OP_EMIT,     COND_NEVER, STEP_HALT};
                default: w = '{OP_HALT,     COND_NEVER, STEP_HALT};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/motor_brake_current_control.sv
// Program: a control tick runs the step program through its emit step once its input is
// accepted, skipping the scaling step when no anti-lock release holds; a reset
// command halts after the first step and a stopped wheel after the second.
// Flow: no new transaction is taken until the program has given its result;
// the input stalls while the program runs, and a stalled output holds its last step.
// Reset (rst_n low, asynchronous): state and output valid clear, registers take
// their default values.
`default_nettype none

module motor_brake_current_control (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_write,
    input  wire logic [mbcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mbcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic signed [14:0]                 wheel_speed,
    input  wire logic signed [14:0]                 prev_wheel_speed,
    input  wire logic [13:0]                        body_ref_speed,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [15:0]                      drive_current,
    output logic signed [14:0]                      speed_reference,
    output logic signed [15:0]                      speed_error,
    output logic                                    release_active,
    output logic                                    clear_regulator
);
    import mbcc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [9:0]  stop_speed_reg;
    logic [14:0] ceiling_reg;
    logic [14:0] floor_reg;
    logic [7:0]  gain_reg;
    logic [9:0]  decay_reg;
    logic [11:0] apply_slew_reg;
    logic [11:0] release_slew_reg;
    logic [13:0] release_min_reg;

    // ---------------- sequencer ----------------
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] pc_reg, pc_next;
    ucode_t            uc;
    logic              cond_true;
    logic              terminal;
    logic              out_free;
    logic              in_accept;

    // ---------------- captured transaction ----------------
    logic               cmd_reg;
    logic signed [14:0] speed_reg;
    logic signed [14:0] prev_reg;
    logic [13:0]        body_reg;

    // ---------------- datapath registers ----------------
    logic [14:0]        aspeed_reg, aspeed_next;   // |wheel_speed|, up to 16384
    logic [14:0]        aprev_reg, aprev_next;
    logic signed [14:0] ref_reg, ref_next;         // decaying speed reference (state)
    logic signed [15:0] cc_reg, cc_next;           // slewed current command (state)
    logic signed [15:0] err_reg, err_next;
    logic [14:0]        lim_reg, lim_next;
    logic signed [15:0] cur_reg, cur_next;
    logic               rel_reg, rel_next;
    logic [11:0]        step_reg, step_next;
    logic signed [23:0] prod_reg, prod_next;

    // ---------------- output register ----------------
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] drive_current_reg, drive_current_next;
    logic signed [14:0] speed_reference_reg, speed_reference_next;
    logic signed [15:0] speed_error_reg, speed_error_next;
    logic               release_active_reg, release_active_next;
    logic               clear_regulator_reg, clear_regulator_next;

    // ---------------- shared multiplier ----------------
    logic signed [16:0] mul_a;
    logic [7:0]         mul_b;
    logic signed [25:0] mul_p;

    // ---------------- scratch ----------------
    logic [14:0]        aref;
    logic signed [15:0] ref16;
    logic signed [15:0] decay16;
    logic signed [23:0] floor24;
    logic signed [23:0] ceil24;
    logic signed [23:0] lim24;
    logic signed [23:0] lim_tmp;
    logic signed [23:0] biased;
    logic [15:0]        acur;
    logic [15:0]        acc;
    logic signed [16:0] cc17;
    logic signed [16:0] cur17;
    logic signed [16:0] hi17;
    logic signed [16:0] lo17;
    logic               slow;
    logic               drop;

    assign uc        = ucode_rom(pc_reg);
    assign terminal  = (uc.op == OP_EMIT) || (uc.op == OP_HALT);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = busy_reg;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        case (uc.cond)
            COND_NEVER: cond_true = 1'b0;
            COND_CMD:   cond_true = cmd_reg;
            COND_STOP:  cond_true = ({1'b0, aspeed_reg} <= {6'd0, stop_speed_reg});
            COND_NREL:  cond_true = !rel_reg;
            default:    cond_true = 1'b0;
        endcase
    end

    // operand selection for the one 17x9 multiplier; product registered in prod_reg
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uc.op)
            OP_MUL_BODY:
            begin
                mul_a = $signed({3'd0, body_reg});
                mul_b = SLOW_RATIO_Q8;
            end
            OP_MUL_LIM:
            begin
                mul_a = $signed({2'd0, aspeed_reg});
                mul_b = gain_reg;
            end
            OP_MUL_ERR:
            begin
                mul_a = {err_reg[15], err_reg};
                mul_b = gain_reg;
            end
            OP_MUL_CUR:
            begin
                mul_a = {cur_reg[15], cur_reg};
                mul_b = RELEASE_RATIO_Q8;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // datapath step
    always_comb
    begin
        aspeed_next          = aspeed_reg;
        aprev_next           = aprev_reg;
        ref_next             = ref_reg;
        cc_next              = cc_reg;
        err_next             = err_reg;
        lim_next             = lim_reg;
        cur_next             = cur_reg;
        rel_next             = rel_reg;
        step_next            = step_reg;
        prod_next            = prod_reg;
        drive_current_next   = drive_current_reg;
        speed_reference_next = speed_reference_reg;
        speed_error_next     = speed_error_reg;
        release_active_next  = release_active_reg;
        clear_regulator_next = clear_regulator_reg;
        out_valid_next       = out_valid_reg && out_stall;
        busy_next            = busy_reg;
        pc_next              = pc_reg;

        aref    = ref_reg[14] ? (~ref_reg + 15'd1) : ref_reg;
        ref16   = {ref_reg[14], ref_reg};
        decay16 = $signed({6'd0, decay_reg});
        floor24 = $signed({9'd0, floor_reg});
        ceil24  = $signed({9'd0, ceiling_reg});
        lim24   = $signed({9'd0, lim_reg});
        lim_tmp = (prod_reg < floor24) ? floor24 : prod_reg;
        biased  = prod_reg + (prod_reg[23] ? 24'sd255 : 24'sd0);
        acur    = cur_reg[15] ? (~cur_reg + 16'd1) : cur_reg;
        acc     = cc_reg[15] ? (~cc_reg + 16'd1) : cc_reg;
        cc17    = {cc_reg[15], cc_reg};
        cur17   = {cur_reg[15], cur_reg};
        hi17    = cc17 + $signed({5'd0, step_reg});
        lo17    = cc17 - $signed({5'd0, step_reg});
        slow    = {1'b0, aspeed_reg, 8'd0} < prod_reg;
        drop    = {1'b0, aprev_reg} > ({1'b0, aspeed_reg} + DROP_LIMIT_RPM);

        if (in_accept)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (busy_reg && !(terminal && !out_free))
        begin
            pc_next = cond_true ? uc.target : pc_reg + 5'd1;
            case (uc.op)
                OP_ABS:
                begin
                    aspeed_next = speed_reg[14] ? (~speed_reg + 15'd1) : speed_reg;
                    aprev_next  = prev_reg[14] ? (~prev_reg + 15'd1) : prev_reg;
                end
                OP_MUL_BODY, OP_MUL_LIM, OP_MUL_ERR, OP_MUL_CUR:
                    prod_next = mul_p[23:0];
                OP_REL:
                    rel_next = (body_reg >= release_min_reg) && (slow || drop);
                OP_SEED:
                begin
                    // re-seed when the reference is spent or points the other way
                    if ((aref <= {5'd0, stop_speed_reg}) || (ref_reg[14] != speed_reg[14]))
                        ref_next = speed_reg;
                end
                OP_DECAY:
                begin
                    if (ref16 > decay16)
                        ref_next = 15'(ref16 - decay16);
                    else if (ref16 < -decay16)
                        ref_next = 15'(ref16 + decay16);
                    else
                        ref_next = '0;
                end
                OP_ERR:
                    err_next = ref16 - {speed_reg[14], speed_reg};
                OP_LIM:
                    lim_next = (lim_tmp > ceil24) ? ceiling_reg : lim_tmp[14:0];
                OP_CUR:
                begin
                    if (prod_reg > lim24)
                        cur_next = $signed({1'b0, lim_reg});
                    else if (prod_reg < -lim24)
                        cur_next = -$signed({1'b0, lim_reg});
                    else
                        cur_next = prod_reg[15:0];
                end
                OP_SCALE:
                    cur_next = biased[23:8];    // divide by 256, toward zero
                OP_FLOOR:
                begin
                    if ((err_reg != 16'sd0) && (acur < {1'b0, floor_reg}))
                        cur_next = err_reg[15] ? -$signed({1'b0, floor_reg})
                                               : $signed({1'b0, floor_reg});
                end
                OP_STEPSEL:
                    step_next = (rel_reg && (acur < acc)) ? release_slew_reg
                                                          : apply_slew_reg;
                OP_SLEW:
                begin
                    if (cur17 > hi17)
                        cc_next = hi17[15:0];
                    else if (cur17 < lo17)
                        cc_next = lo17[15:0];
                    else
                        cc_next = cur_reg;
                end
                OP_EMIT:
                begin
                    drive_current_next   = cc_reg;
                    speed_reference_next = ref_reg;
                    speed_error_next     = err_reg;
                    release_active_next  = rel_reg;
                    clear_regulator_next = 1'b0;
                    out_valid_next       = 1'b1;
                    busy_next            = 1'b0;
                end
                OP_HALT:
                begin
                    // reset command or stopped wheel: clear state, zero result
                    ref_next             = '0;
                    cc_next              = '0;
                    drive_current_next   = '0;
                    speed_reference_next = '0;
                    speed_error_next     = '0;
                    release_active_next  = 1'b0;
                    clear_regulator_next = !cmd_reg;
                    out_valid_next       = 1'b1;
                    busy_next            = 1'b0;
                end
                default:
                    busy_next = 1'b0;
            endcase
        end
    end

    // control, state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            pc_reg           <= '0;
            out_valid_reg    <= 1'b0;
            ref_reg          <= '0;
            cc_reg           <= '0;
            stop_speed_reg   <= 10'd5;
            ceiling_reg      <= 15'd1200;
            floor_reg        <= 15'd150;
            gain_reg         <= 8'd9;
            decay_reg        <= 10'd5;
            apply_slew_reg   <= 12'd22;
            release_slew_reg <= 12'd240;
            release_min_reg  <= 14'd35;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            ref_reg       <= ref_next;
            cc_reg        <= cc_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_STOP_SPEED:      stop_speed_reg   <= cfg_data[9:0];
                    REG_CURRENT_CEILING: ceiling_reg      <= cfg_data[14:0];
                    REG_CURRENT_FLOOR:   floor_reg        <= cfg_data[14:0];
                    REG_GAIN_PER_RPM:    gain_reg         <= cfg_data[7:0];
                    REG_REF_DECAY_STEP:  decay_reg        <= cfg_data[9:0];
                    REG_APPLY_SLEW:      apply_slew_reg   <= cfg_data[11:0];
                    REG_RELEASE_SLEW:    release_slew_reg <= cfg_data[11:0];
                    REG_RELEASE_MIN_REF: release_min_reg  <= cfg_data[13:0];
                    default:             ;
                endcase
            end
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= command;
            speed_reg <= wheel_speed;
            prev_reg  <= prev_wheel_speed;
            body_reg  <= body_ref_speed;
        end
        aspeed_reg          <= aspeed_next;
        aprev_reg           <= aprev_next;
        err_reg             <= err_next;
        lim_reg             <= lim_next;
        cur_reg             <= cur_next;
        rel_reg             <= rel_next;
        step_reg            <= step_next;
        prod_reg            <= prod_next;
        drive_current_reg   <= drive_current_next;
        speed_reference_reg <= speed_reference_next;
        speed_error_reg     <= speed_error_next;
        release_active_reg  <= release_active_next;
        clear_regulator_reg <= clear_regulator_next;
    end

    assign out_valid       = out_valid_reg;
    assign drive_current   = drive_current_reg;
    assign speed_reference = speed_reference_reg;
    assign speed_error     = speed_error_reg;
    assign release_active  = release_active_reg;
    assign clear_regulator = clear_regulator_reg;

    // ---------------- assertions ----------------
    a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (busy_reg && (pc_reg == '0)))
        else $error("accepted transaction did not start the program");

    a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && terminal))
        else $error("result appeared outside a terminal step");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= STEP_HALT))
        else $error("step counter left the program");

    a_command_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cc_reg != 16'sh8000)
        else $error("current command out of range");

endmodule

`default_nettype wire

>>> dv/tb_motor_brake_current_control.sv
module tb_motor_brake_current_control;
    import mbcc_pkg::*;

    // Command codes carried by the one-bit command field
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Q8 ratios and drop limit, widened to signed ints for the predictor
    localparam int SLOW_Q8    = SLOW_RATIO_Q8;
    localparam int RELEASE_Q8 = RELEASE_RATIO_Q8;
    localparam int DROP_RPM   = DROP_LIMIT_RPM;

    localparam int BODY_MAX     = 16383;
    // Allowance past the last taken result; leaves margin beyond a full tick program.
    localparam int DRAIN_CYCLES = 24;
    // Watchdog limit on the whole run, with generous margin over the slowest legal run.
    localparam int CYCLE_LIMIT  = 400000;

    // One expected result of the brake controller
    typedef struct {
        logic signed [15:0] drive;
        logic signed [14:0] speed_ref;
        logic signed [15:0] speed_err;
        logic               antilock;
        logic               reg_clear;
    } brake_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       command;
    logic signed [14:0]         wheel_speed;
    logic signed [14:0]         prev_wheel_speed;
    logic [13:0]                body_ref_speed;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [15:0]         drive_current;
    logic signed [14:0]         speed_reference;
    logic signed [15:0]         speed_error;
    logic                       release_active;
    logic                       clear_regulator;

    // Predictor state: decayed speed reference, slewed current command, and
    // a shadow of the eight configuration registers indexed by REG_*.
    int shadow_regs [8];
    int decayed_ref;
    int brake_cmd;

    brake_result_t expected_results [$];

    // Knobs shared by the stimulus tasks and the output pacing process
    bit sender_gaps;
    bit receiver_gaps;
    int stall_hold_cycles;

    // Run statistics
    int fail_count;
    int items_sent;
    int results_checked;
    int release_results;
    int clear_results;
    int settings_applied;
    int cycle_count;

    motor_brake_current_control u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .wheel_speed      (wheel_speed),
        .prev_wheel_speed (prev_wheel_speed),
        .body_ref_speed   (body_ref_speed),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_current    (drive_current),
        .speed_reference  (speed_reference),
        .speed_error      (speed_error),
        .release_active   (release_active),
        .clear_regulator  (clear_regulator)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int mag_of(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int sign_of(input int v);
        if (v > 0)
            return 1;
        if (v < 0)
            return -1;
        return 0;
    endfunction

    // Move now toward target by at most lim
    function automatic int slew_toward(input int target, input int now, input int lim);
        if (target > now + lim)
            return now + lim;
        if (target < now - lim)
            return now - lim;
        return target;
    endfunction

    // Advance the brake state by one transaction and return its result.
    function automatic brake_result_t predict_brake(
        input logic               cmd,
        input logic signed [14:0] ws,
        input logic signed [14:0] pws,
        input logic [13:0]        body_in
    );
        brake_result_t r;
        int     spd;
        int     aspd;
        int     prev_mag;
        int     body;
        int     err;
        int     err_sign;
        int     lim;
        int     cur;
        int     slew_lim;
        longint prod;
        logic   antilock;

        r.drive     = '0;
        r.speed_ref = '0;
        r.speed_err = '0;
        r.antilock  = 1'b0;
        r.reg_clear = 1'b0;
        spd      = ws;
        aspd     = mag_of(spd);
        prev_mag = mag_of(int'(pws));
        body     = body_in;
        antilock = 1'b0;

        // Clear command: state zeroed, all-zero result with no clear flag
        if (cmd == CMD_CLEAR)
        begin
            decayed_ref = 0;
            brake_cmd   = 0;
            return r;
        end

        // Wheel stopped: state zeroed, regulator flagged for clearing
        if (aspd <= shadow_regs[REG_STOP_SPEED])
        begin
            decayed_ref = 0;
            brake_cmd   = 0;
            r.reg_clear = 1'b1;
            return r;
        end

        // Re-seed the reference when it is spent or points the other way
        if (mag_of(decayed_ref) <= shadow_regs[REG_STOP_SPEED] ||
            sign_of(decayed_ref) != sign_of(spd))
            decayed_ref = spd;
        decayed_ref = slew_toward(0, decayed_ref, shadow_regs[REG_REF_DECAY_STEP]);

        err      = decayed_ref - spd;
        err_sign = sign_of(err);

        // Speed-dependent limit: raised to the floor, then clamped to the ceiling
        prod = longint'(aspd) * shadow_regs[REG_GAIN_PER_RPM];
        if (prod < shadow_regs[REG_CURRENT_FLOOR])
            prod = shadow_regs[REG_CURRENT_FLOOR];
        if (prod > shadow_regs[REG_CURRENT_CEILING])
            prod = shadow_regs[REG_CURRENT_CEILING];
        lim = int'(prod);

        prod = longint'(err) * shadow_regs[REG_GAIN_PER_RPM];
        if (prod < -longint'(lim))
            prod = -longint'(lim);
        if (prod > lim)
            prod = lim;
        cur = int'(prod);

        // Anti-lock release: wheel much slower than the body, or a sharp drop
        if (body >= shadow_regs[REG_RELEASE_MIN_REF])
            antilock = (longint'(aspd) * 256 < longint'(body) * SLOW_Q8) ||
                       (prev_mag > aspd + DROP_RPM);
        if (antilock)
            cur = (cur * RELEASE_Q8) / 256;

        if (err_sign != 0 && mag_of(cur) < shadow_regs[REG_CURRENT_FLOOR])
            cur = err_sign * shadow_regs[REG_CURRENT_FLOOR];

        slew_lim = (antilock && mag_of(cur) < mag_of(brake_cmd)) ?
                   shadow_regs[REG_RELEASE_SLEW] : shadow_regs[REG_APPLY_SLEW];
        brake_cmd = slew_toward(cur, brake_cmd, slew_lim);

        r.drive     = brake_cmd[15:0];
        r.speed_ref = decayed_ref[14:0];
        r.speed_err = err[15:0];
        r.antilock  = antilock;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Output side: pacing of out_stall and result checking
    // ------------------------------------------------------------------

    // After each taken result the receiver may draw a random pause to hold off the
    // next one; the pause counts only cycles where a result is on offer, so
    // the stall really lands on it. A long hold requested by a test stalls
    // for the requested stall_hold_cycles regardless of traffic.
    initial
    begin : output_pacing
        int pause;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_hold_cycles > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (stall_hold_cycles) @(negedge clk);
                out_stall <= 1'b0;
                stall_hold_cycles = 0;
            end
            else if (out_valid && !out_stall)
            begin
                pause = receiver_gaps ? $urandom_range(0, 3) : 0;
                if (pause > 0)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    while (pause > 0)
                    begin
                        @(posedge clk);
                        if (out_valid)
                            pause--;
                    end
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Every taken result is compared against the oldest prediction
    always @(posedge clk)
    begin : result_check
        brake_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction arrived with none outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (drive_current !== want.drive)
                begin
                    $error("drive_current expected %0d got %0d", want.drive, drive_current);
                    fail_count++;
                end
                if (speed_reference !== want.speed_ref)
                begin
                    $error("speed_reference expected %0d got %0d",
                           want.speed_ref, speed_reference);
                    fail_count++;
                end
                if (speed_error !== want.speed_err)
                begin
                    $error("speed_error expected %0d got %0d", want.speed_err, speed_error);
                    fail_count++;
                end
                if (release_active !== want.antilock)
                begin
                    $error("release_active expected %0b got %0b",
                           want.antilock, release_active);
                    fail_count++;
                end
                if (clear_regulator !== want.reg_clear)
                begin
                    $error("clear_regulator expected %0b got %0b",
                           want.reg_clear, clear_regulator);
                    fail_count++;
                end
                results_checked++;
                if (want.antilock)
                    release_results++;
                if (want.reg_clear)
                    clear_results++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one transaction. Called right after the previous acceptance, so
    // the first falling edge either drops valid for a gap or replaces the
    // payload before the next rising edge can take it again.
    task automatic send_tick(input logic cmd, input int ws, input int pws, input int body);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         <= 1'b1;
        command          <= cmd;
        wheel_speed      <= ws[14:0];
        prev_wheel_speed <= pws[14:0];
        body_ref_speed   <= body[13:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(
            predict_brake(command, wheel_speed, prev_wheel_speed, body_ref_speed));
        items_sent++;
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        shadow_regs[idx] = value;
    endtask

    // Program all eight registers once the block has gone quiet
    task automatic apply_setting(input int stop_rpm, input int ceiling, input int floor_cur,
                                 input int gain, input int decay, input int apply_step,
                                 input int fast_step, input int min_ref);
        wait_until_idle();
        write_reg(REG_STOP_SPEED, stop_rpm);
        write_reg(REG_CURRENT_CEILING, ceiling);
        write_reg(REG_CURRENT_FLOOR, floor_cur);
        write_reg(REG_GAIN_PER_RPM, gain);
        write_reg(REG_REF_DECAY_STEP, decay);
        write_reg(REG_APPLY_SLEW, apply_step);
        write_reg(REG_RELEASE_SLEW, fast_step);
        write_reg(REG_RELEASE_MIN_REF, min_ref);
        settings_applied++;
    endtask

    // Mostly realistic braking runs: a wheel decelerating toward standstill
    // with the body reference trailing above it, occasional sharp drops to
    // trip release, and an early end at a stop tick. About one in ten picks is a
    // raw random transaction instead, and runs are sometimes cut by a clear.
    task automatic run_braking(input int count);
        int left;
        int spd;
        int prev;
        int body;
        int len;
        int dir;
        int drop;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_tick(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_TICK,
                          $urandom, $urandom, $urandom);
                left--;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       spd = $urandom_range(0, 60);
                    1:       spd = $urandom_range(0, 600);
                    2:       spd = $urandom_range(0, 4000);
                    default: spd = $urandom_range(0, 16383);
                endcase
                dir  = $urandom_range(0, 1) ? 1 : -1;
                body = spd + $urandom_range(0, 400);
                if (body > BODY_MAX)
                    body = BODY_MAX;
                prev = spd;
                len  = $urandom_range(4, 30);
                while (len > 0 && left > 0)
                begin
                    // occasional sudden slowdown of the wheel
                    drop = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 400)
                                                       : $urandom_range(0, 30);
                    spd  = (spd > drop) ? spd - drop : 0;
                    drop = $urandom_range(0, 25);
                    body = (body > drop) ? body - drop : 0;
                    if ($urandom_range(0, 49) == 0)
                        send_tick(CMD_CLEAR, dir * spd, dir * prev, body);
                    else
                        send_tick(CMD_TICK, dir * spd, dir * prev, body);
                    prev = spd;
                    len--;
                    left--;
                    if (spd <= shadow_regs[REG_STOP_SPEED])
                        len = 0;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked transactions under the reset defaults
    // (stop 5, ceiling 1200, floor 150, gain 9, decay 5, slews 22/240, min ref 35).
    task automatic test_directed_cases();
        send_tick(CMD_CLEAR, 1000, 1000, 500);          // clear with live fields
        send_tick(CMD_TICK, 0, 0, 0);                   // standing still
        send_tick(CMD_TICK, 5, 5, 0);                   // exactly at stop speed
        send_tick(CMD_TICK, -5, -5, 0);
        send_tick(CMD_TICK, 6, 6, 0);                   // just moving, floor forced
        send_tick(CMD_TICK, 16383, 16383, BODY_MAX);    // largest speed, largest body
        send_tick(CMD_TICK, -16384, -16384, 0);         // sign flip re-seeds reference
        send_tick(CMD_TICK, -16384, 16383, BODY_MAX);
        send_tick(CMD_TICK, 300, 300, 1000);            // slow against body: release
        send_tick(CMD_TICK, 300, 330, 100);             // drop of 30 rpm: release
        send_tick(CMD_TICK, 300, 320, 100);             // drop of exactly 20: no release
        send_tick(CMD_TICK, 10, 10, 35);                // body at min ref: release possible
        send_tick(CMD_TICK, 10, 10, 34);                // body under min ref: never
        // steady braking builds the command, then release slews it down fast
        repeat (6) send_tick(CMD_TICK, 1000, 1000, 1000);
        repeat (3) send_tick(CMD_TICK, 1000, 1000, 4000);
        send_tick(CMD_CLEAR, -16384, -16384, BODY_MAX);
    endtask

    // All-zero, all-max but ceiling and floor at 16384, floor above ceiling, then back to defaults
    task automatic test_register_extremes();
        apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
        run_braking(35);
        apply_setting(1023, 16384, 16384, 255, 1023, 4095, 4095, 16383);
        run_braking(35);
        apply_setting(20, 500, 2000, 40, 3, 100, 600, 50);
        run_braking(35);
        apply_setting(5, 1200, 150, 9, 5, 22, 240, 35);
        run_braking(35);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // back-to-back ticks, so the block fills and must stall its input.
    task automatic test_output_backpressure();
        wait_until_idle();
        sender_gaps       = 1'b0;
        stall_hold_cycles = 150;
        for (int i = 0; i < 12; i++)
            send_tick(CMD_TICK, 2000 - 60 * i, 2060 - 60 * i, 3000);
        sender_gaps = 1'b1;
    endtask

    // Random register settings, each followed by a batch of braking traffic;
    // one phase runs the sender without gaps and one the receiver.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            apply_setting(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 40),
                          $urandom_range(0, 16384),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16384)
                                                      : $urandom_range(0, 400),
                          $urandom_range(0, 255),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 20),
                          $urandom_range(0, 4095),
                          $urandom_range(0, 4095),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                      : $urandom_range(0, 200));
            sender_gaps   = (phase != 2);
            receiver_gaps = (phase != 3);
            run_braking(90);
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_valid          = 1'b0;
        command           = CMD_TICK;
        wheel_speed       = '0;
        prev_wheel_speed  = '0;
        body_ref_speed    = '0;
        sender_gaps       = 1'b1;
        receiver_gaps     = 1'b1;
        stall_hold_cycles = 0;
        fail_count        = 0;
        items_sent        = 0;
        results_checked   = 0;
        release_results   = 0;
        clear_results     = 0;
        settings_applied  = 0;
        cycle_count       = 0;

        // Register defaults and cleared state, as the block comes out of reset
        shadow_regs[REG_STOP_SPEED]      = 5;
        shadow_regs[REG_CURRENT_CEILING] = 1200;
        shadow_regs[REG_CURRENT_FLOOR]   = 150;
        shadow_regs[REG_GAIN_PER_RPM]    = 9;
        shadow_regs[REG_REF_DECAY_STEP]  = 5;
        shadow_regs[REG_APPLY_SLEW]      = 22;
        shadow_regs[REG_RELEASE_SLEW]    = 240;
        shadow_regs[REG_RELEASE_MIN_REF] = 35;
        decayed_ref = 0;
        brake_cmd   = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();
        wait_until_idle();

        $display("Run covered %0d input transactions and %0d checked results over %0d settings",
                 items_sent, results_checked, settings_applied);
        $display("  %0d results under anti-lock release, %0d with regulator clear",
                 release_results, clear_results);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
